FILE: rtl/core/life_grid_generation_engine_macros.svh
// Assertion helpers shared by the RTL of the life grid engine.
// Both expect clk and rst_n to be visible where they are used.
`ifndef LIFE_GRID_GENERATION_ENGINE_MACROS_SVH
`define LIFE_GRID_GENERATION_ENGINE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define LGGE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define LGGE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lgge_pkg.sv
`default_nettype none

package lgge_pkg;

    // Grid geometry
    localparam int ROWS  = 64;
    localparam int COLS  = 64;
    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS);

    // Result counters saturate at all ones
    localparam int                 COUNT_W   = 13;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Operation codes
    localparam logic [1:0] FUNC_EDIT  = 2'd0;
    localparam logic [1:0] FUNC_STEP  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // B3/S23 thresholds
    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] SURVIVE_LOW = 4'd2;

    // 3x3 neighborhood: bit 2 is the left column, bit 1 the center, bit 0 the right
    typedef struct packed {
        logic [2:0] up;
        logic [2:0] mid;
        logic [2:0] dn;
    } window_t;

    typedef struct packed {
        logic birth;
        logic death;
        logic next_live;
    } verdict_t;

endpackage

`default_nettype wire

FILE: rtl/core/lgge_ram.sv
`default_nettype none

module lgge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/lgge_cell_rule.sv
`default_nettype none

module lgge_cell_rule
    import lgge_pkg::*;
(
    input  wire window_t  win,
    output verdict_t      verdict
);

    logic [3:0] nbr_count;
    logic       live;

    // Sum the eight neighbors; the center bit is the cell itself
    assign nbr_count = 4'(win.up[2]) + 4'(win.up[1]) + 4'(win.up[0])
                     + 4'(win.mid[2])                + 4'(win.mid[0])
                     + 4'(win.dn[2]) + 4'(win.dn[1]) + 4'(win.dn[0]);

    assign live = win.mid[1];

    assign verdict.birth     = !live && (nbr_count == BIRTH_COUNT);
    assign verdict.death     = live && ((nbr_count < SURVIVE_LOW) || (nbr_count > BIRTH_COUNT));
    assign verdict.next_live = verdict.birth || (live && !verdict.death);

endmodule

`default_nettype wire

FILE: rtl/core/life_grid_generation_engine.sv
`default_nettype none

`include "life_grid_generation_engine_macros.svh"

// Bounded ROWS x COLS Life grid under B3/S23; cells beyond the edge are dead.
// Issue a command by raising start while busy is low; it is taken at that
// clock edge. Every command returns exactly one result beat: strobe is high
// for a single cycle with cell_live, births, deaths and done_res, and the
// receiver must capture it then, as there is no way to hold it off. An edit
// (func 0) does one RAM row read, then the write back with the result. An
// edit outside the grid, and the unused code 3, answer in the cycle after
// acceptance without raising busy. In a generation step (func 1) the
// single cell rule unit visits one cell per cycle, and each row ends with
// its RAM write back and, but for the last row, the fetch of the next row.
// A clear (func 2) zeroes one row of the grid RAM per cycle. After reset
// the same clearing pass runs with busy high and no result.
module life_grid_generation_engine
    import lgge_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         func,
    input  wire logic [5:0]         row_index,
    input  wire logic [5:0]         col_index,
    input  wire logic               set_mode,
    output logic                    strobe,
    output logic                    cell_live,
    output logic [COUNT_W-1:0]      births,
    output logic [COUNT_W-1:0]      deaths,
    output logic                    done_res
);

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;  // zero one RAM row per cycle
    localparam logic [2:0] S_IDLE  = 3'd1;  // wait for a command
    localparam logic [2:0] S_EDIT  = 3'd2;  // row data back, modify and write
    localparam logic [2:0] S_LD0   = 3'd3;  // row 0 arrives, fetch row 1
    localparam logic [2:0] S_LD1   = 3'd4;  // row 1 arrives, start the scan
    localparam logic [2:0] S_SCAN  = 3'd5;  // one cell per cycle
    localparam logic [2:0] S_WB    = 3'd6;  // write the new row, slide window
    localparam logic [2:0] S_SHIFT = 3'd7;  // lower row arrives

    logic [2:0]          state_reg, state_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic                set_mode_reg, set_mode_next;
    logic                clear_emit_reg, clear_emit_next;

    logic                strobe_reg, strobe_next;
    logic                cell_live_reg, cell_live_next;
    logic [COUNT_W-1:0]  births_reg, births_next;
    logic [COUNT_W-1:0]  deaths_reg, deaths_next;
    logic                done_reg, done_next;

    // Old generation rows above, at and below the current row, and the new row
    logic [COLS-1:0]     up_reg, up_next;
    logic [COLS-1:0]     mid_reg, mid_next;
    logic [COLS-1:0]     dn_reg, dn_next;
    logic [COLS-1:0]     new_reg, new_next;

    // Grid RAM: one row of live bits per word
    logic                wr_en;
    logic [ROW_W-1:0]    wr_addr;
    logic [COLS-1:0]     wr_data;
    logic                rd_en;
    logic [ROW_W-1:0]    rd_addr;
    logic [COLS-1:0]     rd_data;

    window_t             win;
    verdict_t            verdict;

    logic                last_row;
    logic                last_col;
    logic                left_ok;
    logic                right_ok;
    logic                edit_in_range;
    logic                edit_bit;
    logic [COLS-1:0]     edit_mask;
    logic [COLS-1:0]     edit_row;

    lgge_ram #(
        .WIDTH (COLS),
        .DEPTH (ROWS)
    ) u_grid_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lgge_cell_rule u_cell_rule (
        .win     (win),
        .verdict (verdict)
    );

    assign last_row = (row_reg == ROW_W'(ROWS - 1));
    assign last_col = (col_reg == COL_W'(COLS - 1));

    // The row registers rotate right during the scan, so the current cell
    // always sits in bit 0, its right neighbor in bit 1 and its left one in
    // the top bit. Mask the wrapped bits at the grid edges: outside is dead.
    assign left_ok  = (col_reg != '0);
    assign right_ok = !last_col;

    assign win.up  = {up_reg[COLS-1] & left_ok, up_reg[0], up_reg[1] & right_ok};
    assign win.mid = {mid_reg[COLS-1] & left_ok, mid_reg[0], mid_reg[1] & right_ok};
    assign win.dn  = {dn_reg[COLS-1] & left_ok, dn_reg[0], dn_reg[1] & right_ok};

    // Row 0 and column 0 are ordinary cells; only indexes past the grid drop
    assign edit_in_range = (32'(row_index) < 32'(ROWS)) && (32'(col_index) < 32'(COLS));

    // Force live, or toggle, the addressed bit of the row that came back
    assign edit_bit  = set_mode_reg | ~rd_data[col_reg];
    assign edit_mask = COLS'(1) << col_reg;
    assign edit_row  = edit_bit ? (rd_data | edit_mask) : (rd_data & ~edit_mask);

    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        set_mode_next   = set_mode_reg;
        clear_emit_next = clear_emit_reg;

        strobe_next     = 1'b0;
        cell_live_next  = cell_live_reg;
        births_next     = births_reg;
        deaths_next     = deaths_reg;
        done_next       = done_reg;

        up_next         = up_reg;
        mid_next        = mid_reg;
        dn_next         = dn_reg;
        new_next        = new_reg;

        wr_en           = 1'b0;
        wr_addr         = row_reg;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = row_reg;

        case (state_reg)
            S_CLEAR:
            begin
                // Zero one row per cycle; a clear command reports at the end
                wr_en = 1'b1;
                if (last_row)
                begin
                    row_next   = '0;
                    state_next = S_IDLE;
                    if (clear_emit_reg)
                    begin
                        clear_emit_next = 1'b0;
                        strobe_next     = 1'b1;
                        cell_live_next  = 1'b0;
                        births_next     = '0;
                        deaths_next     = '0;
                        done_next       = 1'b1;
                    end
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    case (func)
                        FUNC_EDIT:
                        begin
                            if (edit_in_range)
                            begin
                                rd_en         = 1'b1;
                                rd_addr       = ROW_W'(row_index);
                                row_next      = ROW_W'(row_index);
                                col_next      = COL_W'(col_index);
                                set_mode_next = set_mode;
                                state_next    = S_EDIT;
                            end
                            else
                            begin
                                // Off the grid: nothing changes, report done
                                strobe_next    = 1'b1;
                                cell_live_next = 1'b0;
                                births_next    = '0;
                                deaths_next    = '0;
                                done_next      = 1'b1;
                            end
                        end

                        FUNC_STEP:
                        begin
                            rd_en       = 1'b1;
                            rd_addr     = '0;
                            row_next    = '0;
                            births_next = '0;
                            deaths_next = '0;
                            state_next  = S_LD0;
                        end

                        FUNC_CLEAR:
                        begin
                            row_next        = '0;
                            clear_emit_next = 1'b1;
                            state_next      = S_CLEAR;
                        end

                        default:
                        begin
                            // Unused code: no change, an all-zero beat
                            strobe_next    = 1'b1;
                            cell_live_next = 1'b0;
                            births_next    = '0;
                            deaths_next    = '0;
                            done_next      = 1'b0;
                        end
                    endcase
                end
            end

            S_EDIT:
            begin
                wr_en          = 1'b1;
                wr_data        = edit_row;
                strobe_next    = 1'b1;
                cell_live_next = edit_bit;
                births_next    = '0;
                deaths_next    = '0;
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end

            S_LD0:
            begin
                mid_next   = rd_data;
                rd_en      = 1'b1;
                rd_addr    = ROW_W'(1);
                state_next = S_LD1;
            end

            S_LD1:
            begin
                // Above row 0 lies the dead border
                up_next    = '0;
                dn_next    = rd_data;
                col_next   = '0;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                // Advance one cell: rotate the window and shift in the new bit.
                // After a full scan of the row the old rows are back in their places.
                up_next  = {up_reg[0], up_reg[COLS-1:1]};
                mid_next = {mid_reg[0], mid_reg[COLS-1:1]};
                dn_next  = {dn_reg[0], dn_reg[COLS-1:1]};
                new_next = {verdict.next_live, new_reg[COLS-1:1]};
                if (verdict.birth && (births_reg != COUNT_MAX))
                begin
                    births_next = births_reg + COUNT_W'(1);
                end
                if (verdict.death && (deaths_reg != COUNT_MAX))
                begin
                    deaths_next = deaths_reg + COUNT_W'(1);
                end
                if (last_col)
                begin
                    col_next   = '0;
                    state_next = S_WB;
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end

            S_WB:
            begin
                // The old copy of this row stays in mid_reg, so overwriting
                // the RAM row now cannot disturb the next row's decisions
                wr_en   = 1'b1;
                wr_data = new_reg;
                if (last_row)
                begin
                    strobe_next    = 1'b1;
                    cell_live_next = 1'b0;
                    done_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    up_next  = mid_reg;
                    mid_next = dn_reg;
                    if ((32'(row_reg) + 32'd2) < 32'(ROWS))
                    begin
                        rd_en   = 1'b1;
                        rd_addr = ROW_W'(32'(row_reg) + 32'd2);
                    end
                    row_next   = row_reg + ROW_W'(1);
                    state_next = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                // Below the last row lies the dead border
                if ((32'(row_reg) + 32'd1) < 32'(ROWS))
                begin
                    dn_next = rd_data;
                end
                else
                begin
                    dn_next = '0;
                end
                state_next = S_SCAN;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state; reset starts the clearing pass over the grid RAM
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            row_reg        <= '0;
            col_reg        <= '0;
            set_mode_reg   <= 1'b0;
            clear_emit_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            cell_live_reg  <= 1'b0;
            births_reg     <= '0;
            deaths_reg     <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            set_mode_reg   <= set_mode_next;
            clear_emit_reg <= clear_emit_next;
            strobe_reg     <= strobe_next;
            cell_live_reg  <= cell_live_next;
            births_reg     <= births_next;
            deaths_reg     <= deaths_next;
            done_reg       <= done_next;
        end
    end

    // Row data registers
    always_ff @(posedge clk)
    begin
        up_reg  <= up_next;
        mid_reg <= mid_next;
        dn_reg  <= dn_next;
        new_reg <= new_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign strobe    = strobe_reg;
    assign cell_live = cell_live_reg;
    assign births    = births_reg;
    assign deaths    = deaths_reg;
    assign done_res  = done_reg;

    `LGGE_ASSERT_NEXT(a_step_goes_busy, start && !busy && (func == FUNC_STEP), busy, "step command did not raise busy")
    `LGGE_ASSERT_NEXT(a_edit_reports, state_reg == S_EDIT, strobe && done_res, "edit write back gave no done beat")
    `LGGE_ASSERT_SAME(a_undone_is_zero, strobe && !done_res, !cell_live && (births == '0) && (deaths == '0), "beat without done carries data")
    `LGGE_ASSERT_SAME(a_col_in_grid, state_reg == S_SCAN, 32'(col_reg) < 32'(COLS), "scan column past grid edge")
    `LGGE_ASSERT_SAME(a_wb_no_overlap, (state_reg == S_WB) && rd_en, rd_addr != wr_addr, "row fetch collides with write back")

endmodule

`default_nettype wire
